### sv/dhbu_pkg.sv
package dhbu_pkg;

    // slot counts of the two point tables
    localparam int BREAK_SLOTS = 8;
    localparam int WATCH_SLOTS = 8;
    localparam int BREAK_IDX_W = (BREAK_SLOTS > 1) ? $clog2(BREAK_SLOTS) : 1;
    localparam int WATCH_IDX_W = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;

    // field widths
    localparam int ADDR_W  = 64;
    localparam int SHIFT_W = 6;
    localparam int KIND_W  = 3;
    localparam int FLAG_W  = 2;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd2;

    // point kinds
    localparam logic [KIND_W-1:0] KIND_SW_BREAK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HW_BREAK    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE_WATCH = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ_WATCH  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ACCESS_WATCH = 3'd4;

    // slot flag bits: software/write in bit 0, hardware/read in bit 1
    localparam logic [FLAG_W-1:0] FLAG_LOW  = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_HIGH = 2'b10;
    localparam logic [FLAG_W-1:0] FLAG_BOTH = 2'b11;
    localparam logic [FLAG_W-1:0] FLAG_NONE = 2'b00;

    typedef enum logic [2:0] {
        CMD_FETCH    = 3'd0,
        CMD_MEM      = 3'd1,
        CMD_INSERT   = 3'd2,
        CMD_REMOVE   = 3'd3,
        CMD_CONTINUE = 3'd4,
        CMD_STEP     = 3'd5,
        CMD_HALT     = 3'd6,
        CMD_KILL     = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_PROCEED     = 3'd0,
        ST_HALTED_WAIT = 3'd1,
        ST_TERMINATED  = 3'd2,
        ST_CMD_OK      = 3'd3,
        ST_TABLE_FULL  = 3'd4,
        ST_BAD_KIND    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KEY,
        S_MATCH,
        S_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic calc_key;
        logic calc_match;
        logic commit;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    // flags that a point kind sets or clears
    function automatic logic [FLAG_W-1:0] kind_flags(input logic [KIND_W-1:0] kind);
        logic [FLAG_W-1:0] f;
        case (kind)
            KIND_SW_BREAK:     f = FLAG_LOW;
            KIND_HW_BREAK:     f = FLAG_HIGH;
            KIND_WRITE_WATCH:  f = FLAG_LOW;
            KIND_READ_WATCH:   f = FLAG_HIGH;
            KIND_ACCESS_WATCH: f = FLAG_BOTH;
            default:           f = FLAG_NONE;
        endcase
        return f;
    endfunction

endpackage

### sv/debug_halt_breakpoint_unit.sv
// Debug halt unit: watches core fetch and memory access events and takes
// debugger commands (insert/remove point, continue, step, halt, kill).
// Input channel: i_in_valid / o_in_ready with one event per transfer.
// Result channel: o_out_valid / i_out_ready, exactly one result per event.
// Configuration channel: i_cfg_valid / o_cfg_ready, always ready, writes
// pc_align_shift; write it only while no event is in flight.
// Flow: an accepted event passes through capture, key shift, slot compare
// and commit in that order, and its result is valid once it commits. The
// next event is taken only after that commit, so the unit does not take a new
// event before it is through with the last; shift and compare each take a stage.
// The result sits in an output register: a stalled receiver holds it and the
// unit takes the next event meanwhile, but it holds that event's commit until
// the register frees up.
// Reset: core halted, debugger informed, no step or kill pending, all slots
// free, pc_align_shift 2, no result pending.
module debug_halt_breakpoint_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [2:0]                          i_cmd,
    input  logic [dhbu_pkg::ADDR_W-1:0]         i_address,
    input  logic [dhbu_pkg::KIND_W-1:0]         i_point_kind,
    input  logic                                i_is_read,
    input  logic                                i_access_fault,
    input  logic                                i_has_jump,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_status,
    output logic                                o_stop_reply,
    output logic                                o_jump_valid,
    output logic [dhbu_pkg::ADDR_W-1:0]         o_jump_address,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dhbu_pkg::SHIFT_W-1:0]        i_cfg_data
);
    import dhbu_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;

    // configuration register always takes a transfer
    assign o_cfg_ready = 1'b1;

    dhbu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    dhbu_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cmd          (i_cmd),
        .i_address      (i_address),
        .i_point_kind   (i_point_kind),
        .i_is_read      (i_is_read),
        .i_access_fault (i_access_fault),
        .i_has_jump     (i_has_jump),
        .i_cfg_write    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_stop_reply   (o_stop_reply),
        .o_jump_valid   (o_jump_valid),
        .o_jump_address (o_jump_address)
    );

endmodule

### sv/dhbu_ctrl.sv
module dhbu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dhbu_pkg::t_dp_sts i_sts,
    output dhbu_pkg::t_dp_ctl o_ctl
);
    import dhbu_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_KEY;
                end
            end
            S_KEY:   n_state = S_MATCH;
            S_MATCH: n_state = S_COMMIT;
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_in_ready     = 1'b0;
        o_ctl          = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctl.capture = i_in_valid;
            end
            S_KEY:   o_ctl.calc_key   = 1'b1;
            S_MATCH: o_ctl.calc_match = 1'b1;
            S_COMMIT: o_ctl.commit    = i_sts.out_free;
            default: o_ctl = '0;
        endcase
    end

endmodule

### sv/dhbu_datapath.sv
module dhbu_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dhbu_pkg::t_dp_ctl                   i_ctl,
    output dhbu_pkg::t_dp_sts                   o_sts,
    input  logic [2:0]                          i_cmd,
    input  logic [dhbu_pkg::ADDR_W-1:0]         i_address,
    input  logic [dhbu_pkg::KIND_W-1:0]         i_point_kind,
    input  logic                                i_is_read,
    input  logic                                i_access_fault,
    input  logic                                i_has_jump,
    input  logic                                i_cfg_write,
    input  logic [dhbu_pkg::SHIFT_W-1:0]        i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [2:0]                          o_status,
    output logic                                o_stop_reply,
    output logic                                o_jump_valid,
    output logic [dhbu_pkg::ADDR_W-1:0]         o_jump_address
);
    import dhbu_pkg::*;

    // configuration
    logic [SHIFT_W-1:0] r_shift;

    // captured item
    t_cmd               r_cmd;
    logic [ADDR_W-1:0]  r_address;
    logic [KIND_W-1:0]  r_kind;
    logic               r_is_read;
    logic               r_fault;
    logic               r_has_jump;
    logic [ADDR_W-1:0]  r_bkey;

    // tables
    logic [ADDR_W-1:0]  r_baddr [BREAK_SLOTS];
    logic [FLAG_W-1:0]  r_bflags [BREAK_SLOTS];
    logic [FLAG_W-1:0]  n_bflags [BREAK_SLOTS];
    logic [ADDR_W-1:0]  r_waddr [WATCH_SLOTS];
    logic [FLAG_W-1:0]  r_wflags [WATCH_SLOTS];
    logic [FLAG_W-1:0]  n_wflags [WATCH_SLOTS];

    // match results
    logic [BREAK_SLOTS-1:0] r_bhit;
    logic [BREAK_SLOTS-1:0] r_bfree;
    logic [WATCH_SLOTS-1:0] r_whit;
    logic [WATCH_SLOTS-1:0] r_wfree;

    // run state
    logic r_halted, n_halted;
    logic r_informed, n_informed;
    logic r_step, n_step;
    logic r_kill, n_kill;

    // result register
    logic              r_out_valid;
    t_status           r_status, n_status;
    logic              r_reply, n_reply;
    logic              r_jv, n_jv;
    logic [ADDR_W-1:0] r_ja, n_ja;

    // priority selects
    logic                   b_any, b_free_any, w_any, w_free_any;
    logic [BREAK_IDX_W-1:0] b_sel, b_free_sel;
    logic [WATCH_IDX_W-1:0] w_sel, w_free_sel;
    logic                   b_alloc, w_alloc;
    logic [FLAG_W-1:0]      kflags, wflags_hit, wmask;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
        end else if (i_cfg_write) begin
            r_shift <= i_cfg_data;
        end
    end

    // item capture and breakpoint key
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_address  <= i_address;
            r_kind     <= i_point_kind;
            r_is_read  <= i_is_read;
            r_fault    <= i_access_fault;
            r_has_jump <= i_has_jump;
        end
        if (i_ctl.calc_key) begin
            r_bkey <= r_address >> r_shift;
        end
    end

    // slot compare
    always_ff @(posedge i_clk) begin
        if (i_ctl.calc_match) begin
            for (int i = 0; i < BREAK_SLOTS; i++) begin
                r_bhit[i]  <= (r_bflags[i] != FLAG_NONE) && (r_baddr[i] == r_bkey);
                r_bfree[i] <= (r_bflags[i] == FLAG_NONE);
            end
            for (int i = 0; i < WATCH_SLOTS; i++) begin
                r_whit[i]  <= (r_wflags[i] != FLAG_NONE) && (r_waddr[i] == r_address);
                r_wfree[i] <= (r_wflags[i] == FLAG_NONE);
            end
        end
    end

    // first hit and first free slot of each table
    always_comb begin
        b_any      = 1'b0;
        b_free_any = 1'b0;
        b_sel      = '0;
        b_free_sel = '0;
        for (int i = BREAK_SLOTS - 1; i >= 0; i--) begin
            if (r_bhit[i]) begin
                b_any = 1'b1;
                b_sel = BREAK_IDX_W'(i);
            end
            if (r_bfree[i]) begin
                b_free_any = 1'b1;
                b_free_sel = BREAK_IDX_W'(i);
            end
        end
    end

    always_comb begin
        w_any      = 1'b0;
        w_free_any = 1'b0;
        w_sel      = '0;
        w_free_sel = '0;
        for (int i = WATCH_SLOTS - 1; i >= 0; i--) begin
            if (r_whit[i]) begin
                w_any = 1'b1;
                w_sel = WATCH_IDX_W'(i);
            end
            if (r_wfree[i]) begin
                w_free_any = 1'b1;
                w_free_sel = WATCH_IDX_W'(i);
            end
        end
    end

    // command execution
    always_comb begin
        n_halted   = r_halted;
        n_informed = r_informed;
        n_step     = r_step;
        n_kill     = r_kill;
        n_bflags   = r_bflags;
        n_wflags   = r_wflags;
        n_status   = ST_PROCEED;
        n_reply    = 1'b0;
        n_jv       = 1'b0;
        n_ja       = '0;
        b_alloc    = 1'b0;
        w_alloc    = 1'b0;
        kflags     = kind_flags(r_kind);
        wflags_hit = w_any ? r_wflags[w_sel] : FLAG_NONE;
        wmask      = r_is_read ? FLAG_HIGH : FLAG_LOW;
        case (r_cmd)
            CMD_FETCH: begin
                if (b_any || r_step) begin
                    n_halted = 1'b1;
                end
                n_step = 1'b0;
                if (r_kill) begin
                    n_status = ST_TERMINATED;
                end else if (n_halted) begin
                    n_status = ST_HALTED_WAIT;
                    if (!r_informed) begin
                        n_reply    = 1'b1;
                        n_informed = 1'b1;
                    end
                end
            end
            CMD_MEM: begin
                if (((wflags_hit & wmask) != FLAG_NONE) || r_fault) begin
                    n_halted = 1'b1;
                end
                if (n_halted) begin
                    if (!r_informed) begin
                        n_reply    = 1'b1;
                        n_informed = 1'b1;
                    end
                    n_status = r_kill ? ST_TERMINATED : ST_HALTED_WAIT;
                end
            end
            default: begin
                // any debugger command stops a running core first
                if (!r_halted) begin
                    if (!r_informed) begin
                        n_reply    = 1'b1;
                        n_informed = 1'b1;
                    end
                    n_halted = 1'b1;
                end
                case (r_cmd)
                    CMD_INSERT, CMD_REMOVE: begin
                        if (!(r_kind inside {KIND_SW_BREAK, KIND_HW_BREAK, KIND_WRITE_WATCH,
                                             KIND_READ_WATCH, KIND_ACCESS_WATCH})) begin
                            n_status = ST_BAD_KIND;
                        end else if (r_kind inside {KIND_SW_BREAK, KIND_HW_BREAK}) begin
                            n_status = ST_CMD_OK;
                            if (r_cmd == CMD_INSERT) begin
                                if (b_any) begin
                                    n_bflags[b_sel] = r_bflags[b_sel] | kflags;
                                end else if (b_free_any) begin
                                    n_bflags[b_free_sel] = kflags;
                                    b_alloc = 1'b1;
                                end else begin
                                    n_status = ST_TABLE_FULL;
                                end
                            end else begin
                                for (int i = 0; i < BREAK_SLOTS; i++) begin
                                    if (r_bhit[i]) begin
                                        n_bflags[i] = r_bflags[i] & ~kflags;
                                    end
                                end
                            end
                        end else begin
                            n_status = ST_CMD_OK;
                            if (r_cmd == CMD_INSERT) begin
                                if (w_any) begin
                                    n_wflags[w_sel] = r_wflags[w_sel] | kflags;
                                end else if (w_free_any) begin
                                    n_wflags[w_free_sel] = kflags;
                                    w_alloc = 1'b1;
                                end else begin
                                    n_status = ST_TABLE_FULL;
                                end
                            end else begin
                                for (int i = 0; i < WATCH_SLOTS; i++) begin
                                    if (r_whit[i]) begin
                                        n_wflags[i] = r_wflags[i] & ~kflags;
                                    end
                                end
                            end
                        end
                    end
                    CMD_CONTINUE, CMD_STEP: begin
                        if (r_has_jump) begin
                            n_jv = 1'b1;
                            n_ja = r_address;
                        end
                        n_halted   = 1'b0;
                        n_informed = 1'b0;
                        n_step     = (r_cmd == CMD_STEP);
                        n_status   = ST_PROCEED;
                    end
                    CMD_HALT: n_status = ST_HALTED_WAIT;
                    CMD_KILL: begin
                        n_kill   = 1'b1;
                        n_status = ST_TERMINATED;
                    end
                    default: n_status = ST_PROCEED;
                endcase
            end
        endcase
    end

    // run state and slot flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted   <= 1'b1;
            r_informed <= 1'b1;
            r_step     <= 1'b0;
            r_kill     <= 1'b0;
            for (int i = 0; i < BREAK_SLOTS; i++) begin
                r_bflags[i] <= FLAG_NONE;
            end
            for (int i = 0; i < WATCH_SLOTS; i++) begin
                r_wflags[i] <= FLAG_NONE;
            end
        end else if (i_ctl.commit) begin
            r_halted   <= n_halted;
            r_informed <= n_informed;
            r_step     <= n_step;
            r_kill     <= n_kill;
            r_bflags   <= n_bflags;
            r_wflags   <= n_wflags;
        end
    end

    // slot addresses, written when a slot is taken
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && b_alloc) begin
            r_baddr[b_free_sel] <= r_bkey;
        end
        if (i_ctl.commit && w_alloc) begin
            r_waddr[w_free_sel] <= r_address;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_status <= n_status;
            r_reply  <= n_reply;
            r_jv     <= n_jv;
            r_ja     <= n_ja;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_stop_reply   = r_reply;
    assign o_jump_valid   = r_jv;
    assign o_jump_address = r_ja;

endmodule

### bench/debug_halt_breakpoint_unit_checker.sv
`timescale 1ns / 1ps

module debug_halt_breakpoint_unit_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [2:0]                  i_cmd,
    input  logic [dhbu_pkg::ADDR_W-1:0] i_address,
    input  logic [dhbu_pkg::KIND_W-1:0] i_point_kind,
    input  logic                        i_is_read,
    input  logic                        i_access_fault,
    input  logic                        i_has_jump,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [2:0]                  i_status,
    input  logic                        i_stop_reply,
    input  logic                        i_jump_valid,
    input  logic [dhbu_pkg::ADDR_W-1:0] i_jump_address,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [dhbu_pkg::SHIFT_W-1:0] i_cfg_data,
    output int                          o_error_count,
    output int                          o_pending_count
);
    import dhbu_pkg::*;

    localparam int BREAK_TABLE = 0;
    localparam int WATCH_TABLE = 1;
    localparam int MAX_SLOTS   = (BREAK_SLOTS > WATCH_SLOTS) ? BREAK_SLOTS : WATCH_SLOTS;

    typedef struct packed {
        t_status           status;
        logic              stop_reply;
        logic              jump_valid;
        logic [ADDR_W-1:0] jump_address;
    } t_answer;

    // shadow copy of the unit state
    logic [SHIFT_W-1:0] align_shift;
    logic               core_halted;
    logic               debugger_told;
    logic               step_armed;
    logic               kill_armed;
    logic [ADDR_W-1:0]  point_addr  [2][MAX_SLOTS];
    logic [FLAG_W-1:0]  point_flags [2][MAX_SLOTS];

    t_answer expected_answers[$];
    int      mismatches = 0;

    function automatic int slot_count(input int tbl);
        return (tbl == BREAK_TABLE) ? BREAK_SLOTS : WATCH_SLOTS;
    endfunction

    // flags of the live slot holding key, none if absent
    function automatic logic [FLAG_W-1:0] flags_at(input int tbl, input logic [ADDR_W-1:0] key);
        int i;
        for (i = 0; i < slot_count(tbl); i++)
            if (point_flags[tbl][i] != FLAG_NONE && point_addr[tbl][i] == key)
                return point_flags[tbl][i];
        return FLAG_NONE;
    endfunction

    // merge into a matching slot, else claim the first free one
    function automatic t_status add_point(input int tbl, input logic [ADDR_W-1:0] key,
                                          input logic [FLAG_W-1:0] f);
        int i;
        for (i = 0; i < slot_count(tbl); i++) begin
            if (point_flags[tbl][i] != FLAG_NONE && point_addr[tbl][i] == key) begin
                point_flags[tbl][i] = point_flags[tbl][i] | f;
                return ST_CMD_OK;
            end
        end
        for (i = 0; i < slot_count(tbl); i++) begin
            if (point_flags[tbl][i] == FLAG_NONE) begin
                point_addr[tbl][i]  = key;
                point_flags[tbl][i] = f;
                return ST_CMD_OK;
            end
        end
        return ST_TABLE_FULL;
    endfunction

    function automatic void drop_point(input int tbl, input logic [ADDR_W-1:0] key,
                                       input logic [FLAG_W-1:0] f);
        int i;
        for (i = 0; i < slot_count(tbl); i++)
            if (point_flags[tbl][i] != FLAG_NONE && point_addr[tbl][i] == key)
                point_flags[tbl][i] = point_flags[tbl][i] & ~f;
    endfunction

    function automatic logic [FLAG_W-1:0] flags_for_kind(input logic [KIND_W-1:0] kind);
        case (kind)
            KIND_SW_BREAK, KIND_WRITE_WATCH: return FLAG_LOW;
            KIND_HW_BREAK, KIND_READ_WATCH:  return FLAG_HIGH;
            default:                         return FLAG_BOTH;
        endcase
    endfunction

    // one stop reply per stop
    function automatic logic tell_debugger();
        if (!debugger_told) begin
            debugger_told = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic reset_shadow();
        int t;
        int i;
        align_shift   = SHIFT_RESET;
        core_halted   = 1'b1;
        debugger_told = 1'b1;
        step_armed    = 1'b0;
        kill_armed    = 1'b0;
        for (t = 0; t < 2; t++) begin
            for (i = 0; i < MAX_SLOTS; i++) begin
                point_addr[t][i]  = '0;
                point_flags[t][i] = FLAG_NONE;
            end
        end
    endtask

    task automatic predict_answer(input t_cmd cmd, input logic [ADDR_W-1:0] addr,
                                  input logic [KIND_W-1:0] kind, input logic rd,
                                  input logic flt, input logic jmp, output t_answer ans);
        logic [ADDR_W-1:0] bkey;
        logic [FLAG_W-1:0] wflags;
        int                tbl;
        ans        = '0;
        ans.status = ST_PROCEED;
        bkey       = addr >> align_shift;
        case (cmd)
            CMD_FETCH: begin
                if (flags_at(BREAK_TABLE, bkey) != FLAG_NONE)
                    core_halted = 1'b1;
                if (step_armed) begin
                    core_halted = 1'b1;
                    step_armed  = 1'b0;
                end
                if (kill_armed) begin
                    ans.status = ST_TERMINATED;
                end else if (core_halted) begin
                    ans.stop_reply = tell_debugger();
                    ans.status     = ST_HALTED_WAIT;
                end
            end
            CMD_MEM: begin
                // watch match on the exact address, reads and writes separately
                wflags = flags_at(WATCH_TABLE, addr);
                if ((wflags & (rd ? FLAG_HIGH : FLAG_LOW)) != FLAG_NONE)
                    core_halted = 1'b1;
                if (flt)
                    core_halted = 1'b1;
                if (core_halted) begin
                    ans.stop_reply = tell_debugger();
                    ans.status     = kill_armed ? ST_TERMINATED : ST_HALTED_WAIT;
                end
            end
            default: begin
                // any debugger command stops a running core first
                if (!core_halted) begin
                    ans.stop_reply = tell_debugger();
                    core_halted    = 1'b1;
                end
                case (cmd)
                    CMD_INSERT, CMD_REMOVE: begin
                        if (kind > KIND_ACCESS_WATCH) begin
                            ans.status = ST_BAD_KIND;
                        end else begin
                            tbl = (kind <= KIND_HW_BREAK) ? BREAK_TABLE : WATCH_TABLE;
                            if (cmd == CMD_INSERT) begin
                                ans.status = add_point(tbl, (tbl == BREAK_TABLE) ? bkey : addr,
                                                       flags_for_kind(kind));
                            end else begin
                                drop_point(tbl, (tbl == BREAK_TABLE) ? bkey : addr,
                                           flags_for_kind(kind));
                                ans.status = ST_CMD_OK;
                            end
                        end
                    end
                    CMD_CONTINUE, CMD_STEP: begin
                        ans.jump_valid   = jmp;
                        ans.jump_address = jmp ? addr : '0;
                        core_halted      = 1'b0;
                        debugger_told    = 1'b0;
                        step_armed       = (cmd == CMD_STEP);
                        ans.status       = ST_PROCEED;
                    end
                    CMD_HALT: begin
                        ans.status = ST_HALTED_WAIT;
                    end
                    CMD_KILL: begin
                        kill_armed = 1'b1;
                        ans.status = ST_TERMINATED;
                    end
                    default: ;
                endcase
            end
        endcase
    endtask

    function automatic void check_field(input string name, input logic [ADDR_W-1:0] want,
                                        input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // track transfers on all three channels
    always @(posedge i_clk) begin : watch_channels
        t_answer ans;
        if (!i_rst_n) begin
            reset_shadow();
            expected_answers.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                align_shift = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                predict_answer(t_cmd'(i_cmd), i_address, i_point_kind, i_is_read,
                               i_access_fault, i_has_jump, ans);
                expected_answers.push_back(ans);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_answers.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual status %0d",
                             $time, i_status);
                    mismatches++;
                end else begin
                    ans = expected_answers.pop_front();
                    check_field("status", ADDR_W'(ans.status), ADDR_W'(i_status));
                    check_field("stop_reply", ADDR_W'(ans.stop_reply), ADDR_W'(i_stop_reply));
                    check_field("jump_valid", ADDR_W'(ans.jump_valid), ADDR_W'(i_jump_valid));
                    check_field("jump_address", ans.jump_address, i_jump_address);
                end
            end
        end
        o_error_count   <= mismatches;
        o_pending_count <= expected_answers.size();
    end

endmodule

### bench/debug_halt_breakpoint_unit_tb.sv
`timescale 1ns / 1ps

module debug_halt_breakpoint_unit_tb;
    import dhbu_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 6;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES     = 12;
    localparam int HOT_POINTS       = 10;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic [2:0]          cmd          = CMD_FETCH;
    logic [ADDR_W-1:0]   address      = '0;
    logic [KIND_W-1:0]   point_kind   = KIND_SW_BREAK;
    logic                is_read      = 1'b0;
    logic                access_fault = 1'b0;
    logic                has_jump     = 1'b0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic [2:0]          status;
    logic                stop_reply;
    logic                jump_valid;
    logic [ADDR_W-1:0]   jump_address;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [SHIFT_W-1:0]  cfg_data     = SHIFT_RESET;

    int                  error_count;
    int                  pending_count;
    int                  quiet_cycles  = 0;
    int                  hold_requests = 0;
    bit                  idling_on     = 1'b1;
    logic [ADDR_W-1:0]   hot_addr [HOT_POINTS];

    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    debug_halt_breakpoint_unit i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_cmd          (cmd),
        .i_address      (address),
        .i_point_kind   (point_kind),
        .i_is_read      (is_read),
        .i_access_fault (access_fault),
        .i_has_jump     (has_jump),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_status       (status),
        .o_stop_reply   (stop_reply),
        .o_jump_valid   (jump_valid),
        .o_jump_address (jump_address),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    debug_halt_breakpoint_unit_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_cmd           (cmd),
        .i_address       (address),
        .i_point_kind    (point_kind),
        .i_is_read       (is_read),
        .i_access_fault  (access_fault),
        .i_has_jump      (has_jump),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_status        (status),
        .i_stop_reply    (stop_reply),
        .i_jump_valid    (jump_valid),
        .i_jump_address  (jump_address),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_error_count   (error_count),
        .o_pending_count (pending_count)
    );

    // offer one event, with an optional idle burst ahead of it
    task automatic offer_event(input t_cmd c, input logic [ADDR_W-1:0] a,
                               input logic [KIND_W-1:0] k, input logic rd,
                               input logic flt, input logic jmp);
        int gap;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        address      <= a;
        point_kind   <= k;
        is_read      <= rd;
        access_fault <= flt;
        has_jump     <= jmp;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // register write only once every result is back
    task automatic set_align_shift(input logic [SHIFT_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // free every slot the hot addresses may hold under the current shift
    task automatic clear_hot_points();
        int i;
        for (i = 0; i < HOT_POINTS; i++) begin
            offer_event(CMD_REMOVE, hot_addr[i], KIND_SW_BREAK, 1'($urandom_range(0, 1)), 1'b0,
                        1'($urandom_range(0, 1)));
            offer_event(CMD_REMOVE, hot_addr[i], KIND_HW_BREAK, 1'($urandom_range(0, 1)), 1'b0,
                        1'($urandom_range(0, 1)));
            offer_event(CMD_REMOVE, hot_addr[i], KIND_ACCESS_WATCH, 1'($urandom_range(0, 1)),
                        1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    // random traffic centered on the hot addresses so points get hit
    task automatic offer_random_events(input int count);
        int                n;
        int                pick;
        int                slot;
        logic [ADDR_W-1:0] a;
        logic [KIND_W-1:0] k;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, HOT_POINTS - 1);
            a    = {$urandom, $urandom};
            k    = KIND_W'($urandom_range(0, 7));
            if (pick < 36) begin
                // fetch on or just beside a point
                if ($urandom_range(0, 3) != 0)
                    a = hot_addr[slot] ^ ADDR_W'($urandom_range(0, 7));
                offer_event(CMD_FETCH, a, k, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick < 60) begin
                if ($urandom_range(0, 9) < 7)
                    a = hot_addr[slot];
                offer_event(CMD_MEM, a, k, 1'($urandom_range(0, 1)),
                            $urandom_range(0, 11) == 0, 1'($urandom_range(0, 1)));
            end else if (pick < 82) begin
                // mostly valid kinds, now and then a bad one
                if ($urandom_range(0, 7) != 0)
                    k = KIND_W'($urandom_range(0, 4));
                offer_event((pick < 72) ? CMD_INSERT : CMD_REMOVE, hot_addr[slot], k,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
            end else if (pick < 92) begin
                offer_event(CMD_CONTINUE, a, k, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick < 97) begin
                offer_event(CMD_STEP, a, k, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                offer_event(CMD_HALT, a, k, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // result side: random stall bursts plus one long hold on request
    initial begin : result_sink
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        forever begin
            @(negedge clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 7);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // end the run when no transfer happens for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int i;
        for (i = 0; i < HOT_POINTS; i++)
            hot_addr[i] = {$urandom, $urandom};
        hot_addr[0] = '0;
        hot_addr[1] = '1;
        hot_addr[2] = {1'b1, {(ADDR_W-1){1'b0}}};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: core starts halted with the default shift
        offer_event(CMD_FETCH, hot_addr[8], KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_INSERT, hot_addr[8] & ~64'h3, KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_INSERT, hot_addr[8] | 64'h2, KIND_HW_BREAK, 1'b1, 1'b0, 1'b0);
        offer_event(CMD_INSERT, hot_addr[1], KIND_WRITE_WATCH, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_INSERT, hot_addr[2], KIND_READ_WATCH, 1'b1, 1'b0, 1'b0);
        offer_event(CMD_INSERT, hot_addr[0], KIND_ACCESS_WATCH, 1'b0, 1'b0, 1'b0);
        // bad kinds leave the tables alone
        offer_event(CMD_INSERT, hot_addr[3], 3'd7, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_REMOVE, hot_addr[0], 3'd5, 1'b0, 1'b0, 1'b0);
        // resume with a jump, then hit the breakpoint inside its aligned window
        offer_event(CMD_CONTINUE, '1, KIND_SW_BREAK, 1'b1, 1'b1, 1'b1);
        offer_event(CMD_FETCH, hot_addr[8] | 64'h3, KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_STEP, '0, KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_FETCH, hot_addr[9], KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        // write watch, access watch, faulting access
        offer_event(CMD_CONTINUE, '0, KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_MEM, hot_addr[1], KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_CONTINUE, '0, KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_MEM, hot_addr[0], KIND_SW_BREAK, 1'b1, 1'b0, 1'b0);
        offer_event(CMD_CONTINUE, '0, KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_MEM, hot_addr[9], KIND_SW_BREAK, 1'b0, 1'b1, 1'b0);
        offer_event(CMD_HALT, '0, KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_REMOVE, hot_addr[8], KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_REMOVE, hot_addr[8], KIND_HW_BREAK, 1'b0, 1'b0, 1'b0);
        // fill the watch table until it overflows
        for (i = 3; i < 8; i++)
            offer_event(CMD_INSERT, hot_addr[i], KIND_READ_WATCH, 1'b1, 1'b0, 1'b0);
        offer_event(CMD_INSERT, hot_addr[9], KIND_READ_WATCH, 1'b1, 1'b0, 1'b0);
        clear_hot_points();

        // random phases across shift settings, extremes first
        set_align_shift(6'd0);
        offer_random_events(80);
        clear_hot_points();
        set_align_shift(6'd63);
        offer_random_events(50);
        clear_hot_points();
        set_align_shift(SHIFT_W'($urandom_range(1, 62)));
        hold_requests++;
        offer_random_events(80);
        clear_hot_points();

        // last part runs without any idling
        idling_on = 1'b0;
        set_align_shift(6'd3);
        offer_random_events(60);

        // kill stays pending: running accesses still proceed, fetches terminate
        offer_event(CMD_CONTINUE, {$urandom, $urandom}, KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_KILL, {$urandom, $urandom}, 3'd6, 1'b1, 1'b1, 1'b1);
        offer_event(CMD_CONTINUE, {$urandom, $urandom}, KIND_SW_BREAK, 1'b0, 1'b0, 1'b1);
        offer_event(CMD_MEM, {$urandom, $urandom}, KIND_SW_BREAK, 1'b1, 1'b0, 1'b0);
        offer_event(CMD_FETCH, {$urandom, $urandom}, KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_MEM, {$urandom, $urandom}, KIND_SW_BREAK, 1'b0, 1'b1, 1'b0);
        offer_event(CMD_STEP, {$urandom, $urandom}, KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);
        offer_event(CMD_FETCH, {$urandom, $urandom}, KIND_SW_BREAK, 1'b0, 1'b0, 1'b0);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
